FILE: hdl/epp_pkg.sv
// shared constants and types of the escape markup parser
`default_nettype none

package epp_pkg;

  // markup characters
  localparam logic [7:0] CH_ESC    = 8'h24;  // '$'
  localparam logic [7:0] CH_LINK   = 8'h4C;  // 'L'
  localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
  localparam logic [7:0] CH_EXEC   = 8'h45;  // 'E'
  localparam logic [7:0] CH_FG     = 8'h21;  // '!'
  localparam logic [7:0] CH_BG     = 8'h2A;  // '*'
  localparam logic [7:0] CH_CLEAR  = 8'h43;  // 'C'

  // result status codes
  localparam logic [1:0] ST_CONSUMED = 2'd0;
  localparam logic [1:0] ST_OBJECT   = 2'd1;
  localparam logic [1:0] ST_PLAIN    = 2'd2;

  // object kinds
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_CLEAR = 3'd1;
  localparam logic [2:0] K_FG    = 3'd2;
  localparam logic [2:0] K_BG    = 3'd3;
  localparam logic [2:0] K_EXEC  = 3'd4;

  // name length and store limit
  localparam int LEN_W     = 5;
  localparam int STORE_MAX = 31;

  // command from the classifier to the result stage
  typedef struct packed {
    logic             replay;  // replay the stored name, len characters
    logic [1:0]       status;
    logic [2:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // name store write port
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } name_wr_t;

endpackage

`default_nettype wire

FILE: hdl/epp_ifs.sv
// valid/ready channel interfaces for input bytes and result words
`default_nettype none

interface epp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface epp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] object_kind;
  logic [7:0] data;
  logic [4:0] name_len;
  logic       last;

  modport source (output valid, output status, output object_kind, output data,
                  output name_len, output last, input ready);
  modport sink   (input valid, input status, input object_kind, input data,
                  input name_len, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/epp_front.sv
// front end: accepts bytes, tracks the escape mode, fills the name store
`default_nettype none

module epp_front import epp_pkg::*; #(
  parameter int CAP = 31
) (
  input  logic     clk,
  input  logic     rst,
  epp_in_if.sink   bytes,
  output cmd_t     cmd,
  output logic     push,
  input  logic     full,
  input  logic     replay_done,
  output name_wr_t wr
);

  typedef enum logic [2:0] {
    M_IDLE, M_WAIT, M_SWALLOW, M_FG, M_BG, M_EXEC
  } mode_t;

  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);

  mode_t            mode, mode_next;
  logic [LEN_W-1:0] count, count_next;
  logic             busy;
  logic             accept;

  // hold off name bytes while the previous name is still being replayed
  assign bytes.ready = !full && !(mode == M_EXEC && busy);
  assign accept      = bytes.valid && bytes.ready;
  assign push        = accept;

  // classify the byte against the current mode
  always_comb begin
    mode_next  = mode;
    count_next = count;
    cmd        = '{replay: 1'b0, status: ST_CONSUMED, kind: K_NONE,
                   data: 8'd0, len: '0};
    wr.en      = 1'b0;
    wr.addr    = count;
    wr.data    = bytes.ch;
    unique case (mode)
      M_IDLE: begin
        if (bytes.ch == CH_ESC) begin
          count_next = '0;
          mode_next  = M_WAIT;
        end else begin
          cmd.status = ST_PLAIN;
          cmd.data   = bytes.ch;
        end
      end
      M_WAIT: begin
        if (bytes.ch == CH_LINK || bytes.ch == CH_BUTTON) begin
          mode_next = M_SWALLOW;
        end else if (bytes.ch == CH_EXEC) begin
          mode_next = M_EXEC;
        end else if (bytes.ch == CH_FG) begin
          mode_next = M_FG;
        end else if (bytes.ch == CH_BG) begin
          mode_next = M_BG;
        end else if (bytes.ch == CH_CLEAR) begin
          mode_next  = M_IDLE;
          cmd.status = ST_OBJECT;
          cmd.kind   = K_CLEAR;
        end else begin
          mode_next  = M_IDLE;
          cmd.status = ST_PLAIN;
          cmd.data   = bytes.ch;
        end
      end
      M_FG, M_BG: begin
        mode_next  = M_IDLE;
        cmd.status = ST_OBJECT;
        cmd.kind   = (mode == M_FG) ? K_FG : K_BG;
        cmd.data   = bytes.ch;
      end
      M_EXEC: begin
        if (bytes.ch == CH_ESC) begin
          mode_next  = M_IDLE;
          cmd.status = ST_OBJECT;
          cmd.kind   = K_EXEC;
          cmd.len    = count;
          cmd.replay = (count != '0);
        end else if (bytes.ch != 8'd0 && count < CAP_L) begin
          wr.en      = accept;
          count_next = count + LEN_W'(1);
        end
      end
      default: begin
        // swallowed byte after a link or button selector
        mode_next = M_IDLE;
      end
    endcase
  end

  // mode, name count and replay tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        count <= count_next;
      end
      if (accept && cmd.replay) begin
        busy <= 1'b1;
      end else if (replay_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/epp_fifo.sv
// two-entry command queue between front and back
`default_nettype none

module epp_fifo import epp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t wdata,
  input  logic push,
  output logic full,
  output cmd_t rdata,
  output logic valid,
  input  logic pop
);

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = q[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/epp_back.sv
// back end: name store, name replay and the output register
`default_nettype none

module epp_back import epp_pkg::*; #(
  parameter int CAP = 31
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      pop,
  input  name_wr_t  wr,
  output logic      replay_done,
  epp_out_if.source results
);

  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_SEND} bstate_t;

  bstate_t          state;
  logic [7:0]       mem [CAP];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] n;
  logic             out_free;
  logic             out_load;
  logic             last_char;

  logic             out_v;
  logic [1:0]       out_status;
  logic [2:0]       out_kind;
  logic [7:0]       out_data;
  logic [LEN_W-1:0] out_len;
  logic             out_last;

  assign out_free    = !out_v || results.ready;
  assign last_char   = (LEN_W'(idx) + LEN_W'(1) == n);
  assign pop         = (state == B_IDLE) && cmd_valid && out_free;
  assign replay_done = (state == B_SEND) && out_free && last_char;

  // a new word enters the output register
  assign out_load = (pop && !cmd.replay) || ((state == B_SEND) && out_free);

  assign results.valid       = out_v;
  assign results.status      = out_status;
  assign results.object_kind = out_kind;
  assign results.data        = out_data;
  assign results.name_len    = out_len;
  assign results.last        = out_last;

  // name store, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    rd_data <= mem[idx];
  end

  // result sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_v <= 1'b0;
    end else begin
      out_v <= out_load || (out_v && !results.ready);
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            if (cmd.replay) begin
              n     <= cmd.len;
              idx   <= '0;
              state <= B_READ;
            end else begin
              out_status <= cmd.status;
              out_kind   <= cmd.kind;
              out_data   <= cmd.data;
              out_len    <= cmd.len;
              out_last   <= 1'b1;
            end
          end
        end
        B_READ: begin
          state <= B_SEND;
        end
        B_SEND: begin
          if (out_free) begin
            out_status <= ST_OBJECT;
            out_kind   <= K_EXEC;
            out_data   <= rd_data;
            out_len    <= n;
            out_last   <= last_char;
            if (last_char) begin
              state <= B_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= B_READ;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/escape_markup_parser.sv
// top level of the dollar-escape markup parser
//
//  channel   dir   handshake      word
//  bytes     in    valid/ready    ch[7:0]
//  results   out   valid/ready    status, object_kind, data, name_len, last
//
// The front takes a byte per cycle while the two-entry queue has room, save
// for name bytes during a replay.
// A closing '$' of a non-empty execute name yields name_len words, each read
// through the registered read of the name store before it is sent.
// During a replay the front holds off further name bytes until it ends.
// Synchronous active-high reset returns to outside any escape; no clearing pass.
// Either side may stall: the queue and the output register decouple them.
`default_nettype none

module escape_markup_parser import epp_pkg::*; #(
  parameter int NAME_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst,
  epp_in_if.sink    bytes,
  epp_out_if.source results
);

  localparam int CAP = (NAME_BYTES - 1 > STORE_MAX) ? STORE_MAX : NAME_BYTES - 1;

  cmd_t     f_cmd, q_cmd;
  logic     push, full, q_valid, pop, replay_done;
  name_wr_t wr;

  epp_front #(.CAP(CAP)) u_front (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .cmd         (f_cmd),
    .push        (push),
    .full        (full),
    .replay_done (replay_done),
    .wr          (wr)
  );

  epp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wdata (f_cmd),
    .push  (push),
    .full  (full),
    .rdata (q_cmd),
    .valid (q_valid),
    .pop   (pop)
  );

  epp_back #(.CAP(CAP)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (q_cmd),
    .cmd_valid   (q_valid),
    .pop         (pop),
    .wr          (wr),
    .replay_done (replay_done),
    .results     (results)
  );

endmodule

`default_nettype wire

FILE: hdl/epp_checker.sv
// port-level checks on the parser output, bound to the top level
`default_nettype none

module epp_checker import epp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [2:0] object_kind,
  input logic [7:0] data,
  input logic [4:0] name_len,
  input logic       last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(last)
      && $stable(status) && $stable(object_kind) && $stable(name_len))
    else $error("stalled result word changed");

  // only objects carry a kind or a length
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OBJECT |-> object_kind == K_NONE && name_len == 5'd0)
    else $error("non-object word with kind or length");

  // consumed bytes give a single empty word
  a_cons: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CONSUMED |-> data == 8'd0 && last)
    else $error("consumed word malformed");

  // only a name replay spans several words
  a_multi: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OBJECT && object_kind == K_EXEC
      && name_len != 5'd0)
    else $error("multi-word run outside a name replay");

endmodule

bind escape_markup_parser epp_checker u_epp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .status      (results.status),
  .object_kind (results.object_kind),
  .data        (results.data),
  .name_len    (results.name_len),
  .last        (results.last)
);

`default_nettype wire

FILE: tb/tb_escape_markup_parser.sv
// self-checking testbench for the escape markup parser: directed and random byte streams
`timescale 1ns / 100ps

module tb_escape_markup_parser;
  import epp_pkg::*;

  localparam int NAME_BYTES = 32;
  localparam int NAME_CAP   = (NAME_BYTES - 1 > STORE_MAX) ? STORE_MAX : NAME_BYTES - 1;
  localparam int RANDOM_BYTES = 320;
  localparam int MAX_REPORTS  = 10;

  // parser position as tracked by the predictor
  typedef enum logic [2:0] {
    PM_IDLE, PM_ESCAPE, PM_SWALLOW, PM_FG, PM_BG, PM_NAME
  } parse_mode_t;

  // one result word
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] kind;
    logic [7:0] data;
    logic [4:0] len;
    logic       last;
  } result_word_t;

  // one byte waiting to go out, optionally held until all results are back
  typedef struct packed {
    logic [7:0] ch;
    logic       drain;
  } markup_byte_t;

  logic clk;
  logic rst;

  epp_in_if  bytes_if ();
  epp_out_if results_if ();

  escape_markup_parser #(.NAME_BYTES(NAME_BYTES)) dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if)
  );

  markup_byte_t markup_bytes [$];
  result_word_t predicted_words [$];

  // predictor state
  parse_mode_t parse_mode;
  logic [7:0]  name_chars [NAME_CAP];
  int          name_cnt;

  // bookkeeping
  int bytes_accepted;
  int words_checked;
  int error_count;
  int names_replayed;
  int longest_name;

  // sender burst shaping and receiver stall pattern
  int burst_left;
  int gap_left;
  int stall_cycle;
  int stall_hold;
  logic stall_level;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic void queue_byte(input logic [7:0] ch, input logic drain = 1'b0);
    markup_bytes.push_back('{ch: ch, drain: drain});
  endfunction

  // work out the result words that one accepted byte causes
  function automatic void decode_byte(input logic [7:0] ch);
    result_word_t w;
    logic replayed;
    w = '{status: ST_CONSUMED, kind: K_NONE, data: 8'h00, len: 5'd0, last: 1'b1};
    replayed = 1'b0;
    case (parse_mode)
      PM_IDLE: begin
        if (ch == CH_ESC) begin
          name_cnt = 0;
          parse_mode = PM_ESCAPE;
        end else begin
          w.status = ST_PLAIN;
          w.data = ch;
        end
      end
      PM_ESCAPE: begin
        parse_mode = PM_IDLE;
        if (ch == CH_LINK || ch == CH_BUTTON) parse_mode = PM_SWALLOW;
        else if (ch == CH_EXEC) parse_mode = PM_NAME;
        else if (ch == CH_FG) parse_mode = PM_FG;
        else if (ch == CH_BG) parse_mode = PM_BG;
        else if (ch == CH_CLEAR) begin
          w.status = ST_OBJECT;
          w.kind = K_CLEAR;
        end else begin
          // unknown selector, the dollar is lost
          w.status = ST_PLAIN;
          w.data = ch;
        end
      end
      PM_SWALLOW: parse_mode = PM_IDLE;
      PM_FG, PM_BG: begin
        w.status = ST_OBJECT;
        w.kind = (parse_mode == PM_FG) ? K_FG : K_BG;
        w.data = ch;
        parse_mode = PM_IDLE;
      end
      PM_NAME: begin
        if (ch == CH_ESC) begin
          // closing dollar replays the stored name
          parse_mode = PM_IDLE;
          w.status = ST_OBJECT;
          w.kind = K_EXEC;
          names_replayed++;
          if (name_cnt > longest_name) longest_name = name_cnt;
          for (int i = 0; i < name_cnt; i++) begin
            w.data = name_chars[i];
            w.len = name_cnt[4:0];
            w.last = (i == name_cnt - 1);
            predicted_words.push_back(w);
          end
          replayed = (name_cnt != 0);
        end else if (ch != 8'h00 && name_cnt < NAME_CAP) begin
          name_chars[name_cnt] = ch;
          name_cnt++;
        end
      end
      default: parse_mode = PM_IDLE;
    endcase
    if (!replayed) predicted_words.push_back(w);
  endfunction

  // byte driver: bursts with random gaps, some bytes wait for a full drain
  always @(posedge clk) begin : byte_driver
    markup_byte_t item;
    if (rst) begin
      bytes_if.valid <= 1'b0;
      bytes_if.ch <= 8'h00;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
      parse_mode = PM_IDLE;
      name_cnt = 0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        decode_byte(bytes_if.ch);
        bytes_accepted++;
      end
      if (!bytes_if.valid || bytes_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          bytes_if.valid <= 1'b0;
        end else if (markup_bytes.size() != 0 &&
                     !(markup_bytes[0].drain && predicted_words.size() != 0)) begin
          item = markup_bytes.pop_front();
          bytes_if.valid <= 1'b1;
          bytes_if.ch <= item.ch;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each word against the oldest prediction, drive ready
  always @(posedge clk) begin : result_monitor
    result_word_t exp_w;
    logic next_ready;
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_cycle = 0;
      stall_hold = 0;
      stall_level = 1'b1;
    end else begin
      if (results_if.valid && results_if.ready) begin
        words_checked++;
        if (predicted_words.size() == 0) begin
          flag_error($sformatf("unexpected word status=%0d kind=%0d data=%02h len=%0d last=%0d",
                               results_if.status, results_if.object_kind, results_if.data,
                               results_if.name_len, results_if.last));
        end else begin
          exp_w = predicted_words.pop_front();
          if (results_if.status !== exp_w.status ||
              results_if.object_kind !== exp_w.kind ||
              results_if.data !== exp_w.data ||
              results_if.name_len !== exp_w.len ||
              results_if.last !== exp_w.last)
            flag_error({
              $sformatf("word %0d: expected status=%0d kind=%0d data=%02h len=%0d last=%0d",
                        words_checked, exp_w.status, exp_w.kind, exp_w.data, exp_w.len,
                        exp_w.last),
              $sformatf(", got status=%0d kind=%0d data=%02h len=%0d last=%0d",
                        results_if.status, results_if.object_kind, results_if.data,
                        results_if.name_len, results_if.last)});
        end
      end
      // stall pattern rotates: always ready, coin flips, sparse, long runs
      stall_cycle++;
      case ((stall_cycle / 128) % 4)
        0: next_ready = 1'b1;
        1: next_ready = 1'($urandom_range(0, 1));
        2: next_ready = (stall_cycle % 5 == 0);
        default: begin
          if (stall_hold == 0) begin
            stall_level = 1'($urandom_range(0, 1));
            stall_hold = $urandom_range(1, 12);
          end
          stall_hold--;
          next_ready = stall_level;
        end
      endcase
      results_if.ready <= next_ready;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [7:0] directed_seq [$];
    int pick;
    int name_len;
    logic [7:0] b;
    logic drain;
    int drain_wait;

    directed_seq = '{8'h00, 8'hFF,                   // plain extremes
                     CH_ESC, CH_CLEAR,
                     CH_ESC, CH_FG, 8'h00,
                     CH_ESC, CH_BG, 8'hFF,
                     CH_ESC, CH_LINK, 8'h41,
                     CH_ESC, CH_BUTTON, CH_ESC,      // swallowed dollar
                     CH_ESC, 8'h5A,                  // unknown selector
                     CH_ESC, CH_EXEC, 8'h61, 8'h00, CH_ESC,  // zero dropped
                     CH_ESC, CH_EXEC, CH_ESC};       // empty name

    rst = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.ch = 8'h00;
    results_if.ready = 1'b0;
    bytes_accepted = 0;
    words_checked = 0;
    error_count = 0;
    names_replayed = 0;
    longest_name = 0;

    foreach (directed_seq[i]) queue_byte(directed_seq[i]);

    // random sequences, mostly well formed
    drain = 1'b1;
    while (markup_bytes.size() < directed_seq.size() + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise: arbitrary bytes, may leave the parser mid escape
        repeat ($urandom_range(1, 5)) begin
          queue_byte(8'($urandom_range(0, 255)), drain);
          drain = 1'b0;
        end
      end else begin
        queue_byte(CH_ESC, drain);
        if (pick < 20) begin
          queue_byte(CH_CLEAR);
        end else if (pick < 38) begin
          queue_byte($urandom_range(0, 1) ? CH_FG : CH_BG);
          queue_byte(8'($urandom_range(0, 255)));
        end else if (pick < 48) begin
          queue_byte($urandom_range(0, 1) ? CH_LINK : CH_BUTTON);
          queue_byte(8'($urandom_range(0, 255)));
        end else if (pick < 58) begin
          queue_byte(($urandom_range(0, 3) == 0) ? CH_ESC : 8'($urandom_range(0, 255)));
        end else begin
          // execute name, now and then past capacity
          queue_byte(CH_EXEC);
          name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                 : $urandom_range(0, 8);
          repeat (name_len) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_ESC || $urandom_range(0, 11) == 0) b = 8'h00;
            queue_byte(b);
          end
          queue_byte(CH_ESC);
        end
      end
      drain = ($urandom_range(0, 29) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for every byte to go out and every word to come back
    drain_wait = 0;
    while ((markup_bytes.size() != 0 || bytes_if.valid) && drain_wait < 200000) begin
      @(posedge clk);
      drain_wait++;
    end
    drain_wait = 0;
    while (predicted_words.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (40) @(posedge clk);

    if (predicted_words.size() != 0)
      flag_error($sformatf("%0d predicted words never arrived", predicted_words.size()));

    $display("run covered %0d bytes and %0d result words", bytes_accepted, words_checked);
    $display("%0d names replayed (longest %0d chars), %0d mismatches recorded",
             names_replayed, longest_name, error_count);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/epp_pkg.sv
hdl/epp_ifs.sv
hdl/epp_front.sv
hdl/epp_fifo.sv
hdl/epp_back.sv
hdl/escape_markup_parser.sv
hdl/epp_checker.sv
tb/tb_escape_markup_parser.sv
